FILE: hdl/gpg_pkg.sv
// Shared types and constants for the gradient palette generator.
`default_nettype none
package gpg_pkg;

  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 32;
  localparam int INDEX_W    = 4;
  localparam int BWIDTH_W   = 10;
  localparam int COUNT_W    = 5;
  localparam int SCALE_W    = 8;
  localparam int ENTRY_W    = 22;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIV_CNT_W  = 3;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'd7;
  localparam logic [CHAN_W-1:0]    ALPHA    = 8'hFF;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_NEXT  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_COUNT  = 2'd0,
    CFG_REPEAT_MODE = 2'd1,
    CFG_SCALE       = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK_RD,
    ST_SEEK_CHK,
    ST_NEXT_RD,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_PACK
  } state_t;

  typedef struct packed {
    logic mul;
    logic load;
    logic shift;
  } lane_ctrl_t;

endpackage
`default_nettype wire

FILE: hdl/gradient_palette_generator_core.sv
// Top level of the gradient palette generator: band table, sequencer, blend lanes.
//
//  channel  | signals                                            | handshake
//  ---------+----------------------------------------------------+------------------------
//  request  | func band_index band_color band_width band_mode    | start && !busy
//  result   | color entry_index last_entry                       | done, one cycle, no stall
//  config   | cfg_index cfg_data                                 | cfg_wr_en
//
//  A write request is stored from the idle state without going busy. A next-entry
//  request walks the band table twice (find the current entry, then look ahead
//  for the palette end), visiting each band slot through the registered table
//  read. A linear entry adds the next-band read, multiply, load, the 8-step
//  restoring division and a pack step; multiply, load and division run in
//  parallel in three channel lanes. Reset clears position and returns registers
//  to their defaults; the band table is undefined until written.
`default_nettype none
module gradient_palette_generator_core #(
  parameter int MAX_BANDS  = 16,
  parameter int WIDTH_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          func,
  input  wire logic [gpg_pkg::INDEX_W-1:0]   band_index,
  input  wire logic [gpg_pkg::COLOR_W-1:0]   band_color,
  input  wire logic [gpg_pkg::BWIDTH_W-1:0]  band_width,
  input  wire logic                          band_mode,
  input  wire logic                          cfg_wr_en,
  input  wire logic [gpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gpg_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                               done,
  output logic      [gpg_pkg::COLOR_W-1:0]   color,
  output logic      [gpg_pkg::ENTRY_W-1:0]   entry_index,
  output logic                               last_entry
);
  import gpg_pkg::*;

  localparam int BW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int BCW = $clog2(MAX_BANDS + 1);
  localparam int SW  = WIDTH_BITS + SCALE_W;

  logic [COLOR_W-1:0]    mem_color [MAX_BANDS];
  logic [WIDTH_BITS-1:0] mem_width [MAX_BANDS];
  logic                  mem_mode  [MAX_BANDS];
  logic [COLOR_W-1:0]    rd_color;
  logic [WIDTH_BITS-1:0] rd_width;
  logic                  rd_mode;
  logic [BW-1:0]         rd_addr;
  logic                  mem_we;

  logic [COUNT_W-1:0] band_count;
  logic               repeat_mode;
  logic [SCALE_W-1:0] scale;

  state_t               state, state_next;
  logic [BCW-1:0]       band, band_next;
  logic [SW-1:0]        step, step_next;
  logic                 pass, pass_next;
  logic                 restarted, restarted_next;
  logic [ENTRY_W-1:0]   entry_cnt, entry_cnt_next;
  logic [BCW-1:0]       cur_band, cur_band_next;
  logic [SW-1:0]        cur_step, cur_step_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 done_next;
  logic                 last_next;

  logic [3*CHAN_W-1:0] c1_hold;
  logic [COLOR_W-1:0]  color_hold;
  logic [SW-1:0]       w_hold;

  logic [BCW-1:0]    n_used;
  logic [BCW-1:0]    nb;
  logic              last_band;
  logic              raw_band;
  logic [SW-1:0]     entries;
  lane_ctrl_t        lane_ctrl;
  logic [CHAN_W-1:0] q_r, q_g, q_b;

  assign n_used = (band_count == '0) ? BCW'(1) :
                  ((32'(band_count) > MAX_BANDS) ? BCW'(MAX_BANDS) : BCW'(band_count));
  assign last_band = (band == n_used - BCW'(1));
  assign raw_band  = (!repeat_mode && last_band) || !rd_mode;
  assign entries   = (!repeat_mode && last_band) ? SW'(1) : SW'(rd_width) * SW'(scale);
  assign nb        = ((band + BCW'(1)) < n_used) ? band + BCW'(1) : '0;
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_color[BW'(band_index)] <= band_color;
      mem_width[BW'(band_index)] <= WIDTH_BITS'(band_width);
      mem_mode[BW'(band_index)]  <= band_mode;
    end
    rd_color <= mem_color[rd_addr];
    rd_width <= mem_width[rd_addr];
    rd_mode  <= mem_mode[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_count  <= COUNT_W'(1);
      repeat_mode <= 1'b1;
      scale       <= SCALE_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BAND_COUNT:  band_count  <= cfg_data[COUNT_W-1:0];
        CFG_REPEAT_MODE: repeat_mode <= cfg_data[0];
        CFG_SCALE:       scale       <= cfg_data[SCALE_W-1:0];
        default:         band_count  <= band_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      band      <= '0;
      step      <= '0;
      pass      <= 1'b0;
      restarted <= 1'b0;
      entry_cnt <= '0;
      cur_band  <= '0;
      cur_step  <= '0;
      div_cnt   <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      band      <= band_next;
      step      <= step_next;
      pass      <= pass_next;
      restarted <= restarted_next;
      entry_cnt <= entry_cnt_next;
      cur_band  <= cur_band_next;
      cur_step  <= cur_step_next;
      div_cnt   <= div_cnt_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEEK_CHK && !pass && step < entries) begin
      c1_hold <= rd_color[3*CHAN_W-1:0];
      w_hold  <= entries;
      if (raw_band) begin
        color_hold <= rd_color;
      end
    end
    if (state == ST_PACK) begin
      color_hold <= {ALPHA, q_r, q_g, q_b};
    end
    if (done_next) begin
      color       <= color_hold;
      entry_index <= entry_cnt;
      last_entry  <= last_next;
    end
  end

  always_comb begin
    state_next     = state;
    band_next      = band;
    step_next      = step;
    pass_next      = pass;
    restarted_next = restarted;
    entry_cnt_next = entry_cnt;
    cur_band_next  = cur_band;
    cur_step_next  = cur_step;
    div_cnt_next   = div_cnt;
    done_next      = 1'b0;
    last_next      = 1'b0;
    rd_addr        = band[BW-1:0];
    lane_ctrl      = '0;
    mem_we         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_NEXT) begin
            band_next      = cur_band;
            step_next      = cur_step;
            pass_next      = 1'b0;
            restarted_next = 1'b0;
            state_next     = ST_SEEK_RD;
          end else begin
            mem_we = (32'(band_index) < MAX_BANDS);
          end
        end
      end
      ST_SEEK_RD: begin
        if (band >= n_used) begin
          if (pass) begin
            done_next      = 1'b1;
            last_next      = 1'b1;
            cur_band_next  = '0;
            cur_step_next  = '0;
            entry_cnt_next = '0;
            state_next     = ST_IDLE;
          end else if (!restarted) begin
            band_next      = '0;
            step_next      = '0;
            restarted_next = 1'b1;
            entry_cnt_next = '0;
          end else begin
            cur_band_next = '0;
            cur_step_next = '0;
            state_next    = ST_IDLE;
          end
        end else begin
          state_next = ST_SEEK_CHK;
        end
      end
      ST_SEEK_CHK: begin
        if (step < entries) begin
          if (pass) begin
            done_next      = 1'b1;
            cur_band_next  = band;
            cur_step_next  = step;
            entry_cnt_next = entry_cnt + ENTRY_W'(1);
            state_next     = ST_IDLE;
          end else if (raw_band) begin
            step_next  = step + SW'(1);
            pass_next  = 1'b1;
            state_next = ST_SEEK_RD;
          end else begin
            state_next = ST_NEXT_RD;
          end
        end else begin
          band_next  = band + BCW'(1);
          step_next  = '0;
          state_next = ST_SEEK_RD;
        end
      end
      ST_NEXT_RD: begin
        rd_addr    = nb[BW-1:0];
        state_next = ST_MUL;
      end
      ST_MUL: begin
        lane_ctrl.mul = 1'b1;
        state_next    = ST_LOAD;
      end
      ST_LOAD: begin
        lane_ctrl.load = 1'b1;
        div_cnt_next   = '0;
        state_next     = ST_DIV;
      end
      ST_DIV: begin
        lane_ctrl.shift = 1'b1;
        div_cnt_next    = div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_LAST) begin
          state_next = ST_PACK;
        end
      end
      ST_PACK: begin
        step_next  = step + SW'(1);
        pass_next  = 1'b1;
        state_next = ST_SEEK_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  gpg_blend_lane #(.SW(SW)) u_lane_r (
    .clk  (clk),
    .ctrl (lane_ctrl),
    .c1   (c1_hold[23:16]),
    .c2   (rd_color[23:16]),
    .w    (w_hold),
    .s    (step),
    .q    (q_r)
  );

  gpg_blend_lane #(.SW(SW)) u_lane_g (
    .clk  (clk),
    .ctrl (lane_ctrl),
    .c1   (c1_hold[15:8]),
    .c2   (rd_color[15:8]),
    .w    (w_hold),
    .s    (step),
    .q    (q_g)
  );

  gpg_blend_lane #(.SW(SW)) u_lane_b (
    .clk  (clk),
    .ctrl (lane_ctrl),
    .c1   (c1_hold[7:0]),
    .c2   (rd_color[7:0]),
    .w    (w_hold),
    .s    (step),
    .q    (q_b)
  );

endmodule
`default_nettype wire

FILE: hdl/gpg_blend_lane.sv
// One color channel: blend products and a bit-serial rounded division.
`default_nettype none
module gpg_blend_lane #(
  parameter int SW = 18
) (
  input  wire logic                      clk,
  input  wire gpg_pkg::lane_ctrl_t       ctrl,
  input  wire logic [gpg_pkg::CHAN_W-1:0] c1,
  input  wire logic [gpg_pkg::CHAN_W-1:0] c2,
  input  wire logic [SW-1:0]             w,
  input  wire logic [SW-1:0]             s,
  output logic      [gpg_pkg::CHAN_W-1:0] q
);
  import gpg_pkg::*;

  localparam int PW = SW + CHAN_W;
  localparam int NW = SW + CHAN_W + 1;

  logic [PW-1:0] p1;
  logic [PW-1:0] p2;
  logic [NW-1:0] rem;
  logic [NW-1:0] dvs;
  logic [PW-1:0] sum;
  logic          fits;

  assign sum  = p1 + p2;
  assign fits = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      p1 <= PW'(c1) * PW'(w - s);
      p2 <= PW'(c2) * PW'(s);
    end
    if (ctrl.load) begin
      rem <= NW'({sum, 1'b0}) + NW'(w);
      dvs <= NW'(w) << CHAN_W;
      q   <= '0;
    end else if (ctrl.shift) begin
      if (fits) begin
        rem <= rem - dvs;
      end
      q   <= {q[CHAN_W-2:0], fits};
      dvs <= dvs >> 1;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/gpg_checker.sv
// Port-level checks for the gradient palette generator, bound to the top level.
`default_nettype none
module gpg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic func,
  input wire logic done
);
  import gpg_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("block not idle after reset");

  a_next_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_NEXT) |=> busy)
    else $error("next-entry request did not start work");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_WRITE) |=> (!busy && !done))
    else $error("write request produced a result or busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind gradient_palette_generator_core gpg_checker u_gpg_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done)
);
`default_nettype wire
